@@ design/duration_string_to_seconds_macros.svh @@
`ifndef DURATION_STRING_TO_SECONDS_MACROS_SVH
`define DURATION_STRING_TO_SECONDS_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define DSTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsts assertion failed");

// next-cycle implication, checked on clk, off during reset
`define DSTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsts assertion failed");

`endif

@@ design/dsts_pkg.sv @@
package dsts_pkg;

  localparam int TOTAL_WIDTH_DEF = 32;
  localparam int MULT_W          = 32;
  localparam int PENDING_W       = 31;
  localparam int PROD_W          = PENDING_W + MULT_W;
  localparam int OUT_W           = 32;
  localparam int CHAR_W          = 8;
  localparam int CFG_INDEX_W     = 4;
  localparam int REG_IDX_W       = 3;
  localparam int REG_COUNT       = 8;

  localparam logic [PENDING_W-1:0] PENDING_MAX = 31'h7FFF_FFFF;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SECOND,
    REG_MINUTE,
    REG_HOUR,
    REG_DAY,
    REG_WEEK,
    REG_MONTH,
    REG_YEAR,
    REG_LIMIT
  } reg_idx_t;

  localparam logic [MULT_W-1:0] CFG_RESET [REG_COUNT] = '{
    32'd1, 32'd60, 32'd3600, 32'd86400, 32'd604800, 32'd2592000, 32'd31536000,
    32'hFFFF_FFFF
  };

  localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOWER_S = 8'h73;
  localparam logic [CHAR_W-1:0] CH_UPPER_S = 8'h53;
  localparam logic [CHAR_W-1:0] CH_LOWER_M = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_UPPER_M = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_LOWER_H = 8'h68;
  localparam logic [CHAR_W-1:0] CH_UPPER_H = 8'h48;
  localparam logic [CHAR_W-1:0] CH_LOWER_D = 8'h64;
  localparam logic [CHAR_W-1:0] CH_UPPER_D = 8'h44;
  localparam logic [CHAR_W-1:0] CH_LOWER_W = 8'h77;
  localparam logic [CHAR_W-1:0] CH_UPPER_W = 8'h57;
  localparam logic [CHAR_W-1:0] CH_LOWER_Y = 8'h79;
  localparam logic [CHAR_W-1:0] CH_UPPER_Y = 8'h59;

  typedef struct packed {
    logic digit_load;
    logic drop;
    logic unit_load;
    logic div_start;
    logic mul;
    logic add;
    logic clear_all;
    logic out_load;
  } dsts_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic pending_nz;
    logic unit_hit;
    logic div_busy;
    logic div_done;
  } dsts_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dsts_div_stat_t;

endpackage

@@ design/duration_string_to_seconds.sv @@
// Duration string parser: one byte of a string such as 1h30m is taken per
// transaction, and the byte flagged end_of_string yields one result with the
// total in seconds, after which the parse state clears. A digit, a non-digit
// with no nonzero value pending, and a non-digit that is not a unit letter with
// a nonzero multiplier are each handled in the idle state without stalling the
// input. A unit letter with a nonzero multiplier after a nonzero value passes,
// after the accepting step, through the shared two-lane restoring divider of
// width DW = max(TOTAL_WIDTH, 32), which works out limit/mult and total/mult
// one quotient bit per cycle, then a step that multiplies and one that adds.
// Such a letter on an end byte places the result in an emit step. An end byte
// whose result finds the output register occupied and stalled holds the input
// until that register frees; otherwise the output register lets the next byte
// be taken while a result waits.
// Unit multipliers and the total limit are written through the cfg port, which
// is always ready; writes are meant for idle periods only.
`include "duration_string_to_seconds_macros.svh"

module duration_string_to_seconds #(
  parameter int TOTAL_WIDTH = dsts_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dsts_pkg::CHAR_W-1:0]       in_char_code,
  input  logic                              in_end_of_string,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dsts_pkg::OUT_W-1:0]        out_total_seconds,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dsts_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dsts_pkg::MULT_W-1:0]       cfg_data
);

  localparam int DIV_WIDTH = (TOTAL_WIDTH > dsts_pkg::MULT_W) ? TOTAL_WIDTH
                                                              : dsts_pkg::MULT_W;

  dsts_pkg::dsts_cmd_t  cmd;
  dsts_pkg::dsts_stat_t stat;

  assign cfg_ready = 1'b1;

  dsts_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_end_of_string (in_end_of_string),
    .in_stall         (in_stall),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .stat             (stat),
    .cmd              (cmd)
  );

  dsts_datapath #(
    .TOTAL_WIDTH (TOTAL_WIDTH),
    .DIV_WIDTH   (DIV_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_code (in_char_code),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .out_total    (out_total_seconds)
  );

  `DSTS_ASSERT_IMPL(a_div_start_idle, cmd.div_start, !stat.div_busy)
  `DSTS_ASSERT_NEXT(a_div_runs, cmd.div_start, stat.div_busy)
  `DSTS_ASSERT_IMPL(a_busy_stalls, stat.div_busy, in_stall)
  `DSTS_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid || !out_stall)

endmodule

@@ design/dsts_div.sv @@
module dsts_div #(
  parameter int DIV_WIDTH = dsts_pkg::MULT_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dsts_pkg::MULT_W-1:0]  divisor,
  input  logic [DIV_WIDTH-1:0]         dividend_a,
  input  logic [DIV_WIDTH-1:0]         dividend_b,
  output dsts_pkg::dsts_div_stat_t     stat,
  output logic [DIV_WIDTH-1:0]         quo_a,
  output logic [DIV_WIDTH-1:0]         quo_b
);

  localparam int MW = dsts_pkg::MULT_W;
  localparam int CW = (DIV_WIDTH > 1) ? $clog2(DIV_WIDTH) : 1;

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [MW-1:0]     d_r;
  logic [DIV_WIDTH-1:0] q_r   [2];
  logic [MW-1:0]        rem_r [2];
  logic [MW:0]          shifted [2];
  logic [MW:0]          trial   [2];
  logic                 last_step;

  assign last_step = (cnt_r == CW'(DIV_WIDTH - 1));

  // two lanes share the divisor, one quotient bit each per cycle
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      shifted[i] = {rem_r[i], q_r[i][DIV_WIDTH-1]};
      trial[i]   = shifted[i] - {1'b0, d_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (last_step) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r      <= divisor;
      q_r[0]   <= dividend_a;
      q_r[1]   <= dividend_b;
      rem_r[0] <= '0;
      rem_r[1] <= '0;
    end else if (busy_r) begin
      for (int i = 0; i < 2; i++) begin
        if (!trial[i][MW]) begin
          rem_r[i] <= trial[i][MW-1:0];
          q_r[i]   <= {q_r[i][DIV_WIDTH-2:0], 1'b1};
        end else begin
          rem_r[i] <= shifted[i][MW-1:0];
          q_r[i]   <= {q_r[i][DIV_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && last_step;
  assign quo_a     = q_r[0];
  assign quo_b     = q_r[1];

endmodule

@@ design/dsts_datapath.sv @@
module dsts_datapath #(
  parameter int TOTAL_WIDTH = dsts_pkg::TOTAL_WIDTH_DEF,
  parameter int DIV_WIDTH   = dsts_pkg::MULT_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dsts_pkg::CHAR_W-1:0]       in_char_code,
  input  logic                              cfg_valid,
  input  logic [dsts_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dsts_pkg::MULT_W-1:0]       cfg_data,
  input  dsts_pkg::dsts_cmd_t               cmd,
  output dsts_pkg::dsts_stat_t              stat,
  output logic [dsts_pkg::OUT_W-1:0]        out_total
);

  localparam int MW = dsts_pkg::MULT_W;
  localparam int PV = dsts_pkg::PENDING_W;
  localparam int PR = dsts_pkg::PROD_W;
  localparam int PW = (TOTAL_WIDTH > PR) ? TOTAL_WIDTH : PR;
  localparam int GW = DIV_WIDTH + 1;
  localparam int NW = PV + 4;

  logic [MW-1:0]          cfg_r [dsts_pkg::REG_COUNT];
  logic [PV-1:0]          pending_r;
  logic                   digits_r;
  logic [TOTAL_WIDTH-1:0] total_r;
  logic [MW-1:0]          mult_r;
  logic [PR-1:0]          prod_r;
  logic                   ok_r;
  logic [dsts_pkg::OUT_W-1:0] out_total_r;

  logic [3:0]             digit_val;
  logic [NW-1:0]          nv;
  logic [PV-1:0]          pending_nxt;
  logic [MW-1:0]          sel_mult;
  logic                   known;
  logic [PR-1:0]          prod_nxt;
  logic [PW-1:0]          prod_ext;
  logic [GW-1:0]          guard_sum;
  logic                   ok_nxt;
  logic [DIV_WIDTH-1:0]   quo_lim;
  logic [DIV_WIDTH-1:0]   quo_tot;
  dsts_pkg::dsts_div_stat_t div_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dsts_pkg::REG_COUNT; i++) begin
        cfg_r[i] <= dsts_pkg::CFG_RESET[i];
      end
    end else if (cfg_valid &&
                 (cfg_index < dsts_pkg::CFG_INDEX_W'(dsts_pkg::REG_COUNT))) begin
      cfg_r[cfg_index[dsts_pkg::REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // decimal accumulate with saturation
  always_comb begin
    digit_val   = 4'(in_char_code - dsts_pkg::CH_0);
    nv          = (NW'(pending_r) << 3) + (NW'(pending_r) << 1) + NW'(digit_val);
    pending_nxt = (nv > NW'(dsts_pkg::PENDING_MAX)) ? dsts_pkg::PENDING_MAX : nv[PV-1:0];
  end

  always_comb begin
    known    = 1'b1;
    sel_mult = '0;
    case (in_char_code)
      dsts_pkg::CH_LOWER_S, dsts_pkg::CH_UPPER_S: sel_mult = cfg_r[dsts_pkg::REG_SECOND];
      dsts_pkg::CH_LOWER_M:                       sel_mult = cfg_r[dsts_pkg::REG_MINUTE];
      dsts_pkg::CH_LOWER_H, dsts_pkg::CH_UPPER_H: sel_mult = cfg_r[dsts_pkg::REG_HOUR];
      dsts_pkg::CH_LOWER_D, dsts_pkg::CH_UPPER_D: sel_mult = cfg_r[dsts_pkg::REG_DAY];
      dsts_pkg::CH_LOWER_W, dsts_pkg::CH_UPPER_W: sel_mult = cfg_r[dsts_pkg::REG_WEEK];
      dsts_pkg::CH_UPPER_M:                       sel_mult = cfg_r[dsts_pkg::REG_MONTH];
      dsts_pkg::CH_LOWER_Y, dsts_pkg::CH_UPPER_Y: sel_mult = cfg_r[dsts_pkg::REG_YEAR];
      default:                                    known    = 1'b0;
    endcase
  end

  dsts_div #(
    .DIV_WIDTH (DIV_WIDTH)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.div_start),
    .divisor    (sel_mult),
    .dividend_a (DIV_WIDTH'(cfg_r[dsts_pkg::REG_LIMIT])),
    .dividend_b (DIV_WIDTH'(total_r)),
    .stat       (div_stat),
    .quo_a      (quo_lim),
    .quo_b      (quo_tot)
  );

  // overflow guard: value + total/mult <= limit/mult
  always_comb begin
    prod_nxt  = pending_r * mult_r;
    guard_sum = GW'(pending_r) + GW'(quo_tot);
    ok_nxt    = (guard_sum <= GW'(quo_lim));
    prod_ext  = PW'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      pending_r <= '0;
      digits_r  <= 1'b0;
      total_r   <= '0;
    end else begin
      if (cmd.digit_load) begin
        pending_r <= pending_nxt;
        digits_r  <= 1'b1;
      end
      if (cmd.drop || cmd.add) begin
        pending_r <= '0;
        digits_r  <= 1'b0;
      end
      if (cmd.add && ok_r) begin
        total_r <= total_r + prod_ext[TOTAL_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.unit_load) begin
      mult_r <= sel_mult;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
      ok_r   <= ok_nxt;
    end
    if (cmd.out_load) begin
      out_total_r <= dsts_pkg::OUT_W'(total_r);
    end
  end

  assign stat.is_digit   = in_char_code inside {[dsts_pkg::CH_0:dsts_pkg::CH_9]};
  assign stat.pending_nz = digits_r && (pending_r != '0);
  assign stat.unit_hit   = known && (sel_mult != '0);
  assign stat.div_busy   = div_stat.busy;
  assign stat.div_done   = div_stat.done;
  assign out_total       = out_total_r;

endmodule

@@ design/dsts_ctrl.sv @@
module dsts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_end_of_string,
  output logic                  in_stall,
  input  logic                  out_stall,
  output logic                  out_valid,
  input  dsts_pkg::dsts_stat_t  stat,
  output dsts_pkg::dsts_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_ADD,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    last_nxt  = last_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.is_digit) begin
            cmd.digit_load = 1'b1;
          end else if (stat.pending_nz) begin
            if (stat.unit_hit) begin
              cmd.div_start = 1'b1;
              cmd.unit_load = 1'b1;
              last_nxt      = in_end_of_string;
              state_nxt     = S_DIV;
            end else begin
              cmd.drop = 1'b1;
            end
          end
          if (!cmd.div_start && in_end_of_string) begin
            if (slot_free) begin
              cmd.out_load  = 1'b1;
              cmd.clear_all = 1'b1;
            end else begin
              state_nxt = S_EMIT;
            end
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = last_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.clear_all = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
